/* rtl/core/process_queue_manager_assert.svh */
// Assertion macros used by the process queue manager.
`ifndef PROCESS_QUEUE_MANAGER_ASSERT_SVH
`define PROCESS_QUEUE_MANAGER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PQM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/core/pqm_pkg.sv */
// Kind, class, status, CSR index and state codes of the process queue manager.
`timescale 1ns / 1ps
package pqm_pkg;
   localparam logic [1:0] KIND_CREATE    = 2'd0;
   localparam logic [1:0] KIND_SEND      = 2'd1;
   localparam logic [1:0] KIND_COMPLETE  = 2'd2;
   localparam logic [1:0] KIND_TERMINATE = 2'd3;

   localparam logic [1:0] CLASS_PRINTER = 2'd0;
   localparam logic [1:0] CLASS_DISK    = 2'd1;
   localparam logic [1:0] CLASS_CDRW    = 2'd2;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_POOL_FULL = 3'd1;
   localparam logic [2:0] ST_NO_DEV    = 3'd2;
   localparam logic [2:0] ST_BAD_NUM   = 3'd3;
   localparam logic [2:0] ST_Q_EMPTY   = 3'd4;
   localparam logic [2:0] ST_CPU_EMPTY = 3'd5;

   localparam logic [1:0] CSR_PRINTER = 2'd0;
   localparam logic [1:0] CSR_DISK    = 2'd1;
   localparam logic [1:0] CSR_CDRW    = 2'd2;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_INIT  = 7'b0000010,
      S_RD    = 7'b0000100,
      S_EXEC  = 7'b0001000,
      S_MOVE  = 7'b0010000,
      S_FILL  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;
endpackage

/* rtl/core/process_queue_manager.sv */
// Top level of the process queue manager: record memories, FIFO pointers and sequencer.
// An event is taken at a start edge; the sequencer steps through S_RD, S_EXEC, S_MOVE,
// S_FILL and S_DONE, then rsp_valid rises and lasts one cycle. busy drops together with
// the strobe, so the next event can be taken at the edge that ends the strobe and no sooner.
// After reset a clearing pass over MAX_PROCESSES records chains the free list; busy is high.
// The result strobe cannot be stalled; the result shows for one cycle.
`timescale 1ns / 1ps
`include "process_queue_manager_assert.svh"
module process_queue_manager #(
   parameter int MAX_PROCESSES = 64,
   parameter int MAX_DEVICES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_device_class,
   input  logic [4:0]  req_device_number,
   input  logic signed [31:0] req_memory_location,
   input  logic signed [31:0] req_file_length,
   input  logic        req_write_flag,
   input  logic [31:0] req_file_tag,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_moved_pid,
   output logic signed [31:0] rsp_moved_memory,
   output logic signed [31:0] rsp_moved_length,
   output logic        rsp_moved_write,
   output logic [31:0] rsp_moved_tag,
   output logic        rsp_cpu_busy,
   output logic [15:0] rsp_cpu_pid,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);
   import pqm_pkg::*;

   localparam int RW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam int QN = MAX_DEVICES + 1;
   localparam int QW = $clog2(QN);
   localparam logic [QW-1:0] READY_Q = QW'(MAX_DEVICES);

   // Record and link memories, each with one read port and one write port.
   logic [15:0] mem_id    [MAX_PROCESSES];
   logic [31:0] mem_mem   [MAX_PROCESSES];
   logic [31:0] mem_len   [MAX_PROCESSES];
   logic        mem_wr    [MAX_PROCESSES];
   logic [31:0] mem_tag   [MAX_PROCESSES];
   logic [RW-1:0] mem_link [MAX_PROCESSES];

   // Queue pointers are small and read at computed slots; kept in flops.
   logic [RW-1:0] qhead_ff [QN];
   logic [RW-1:0] qtail_ff [QN];
   logic [QN-1:0] qne_ff;

   state_type state_ff;
   logic [4:0] pcnt_ff, dcnt_ff, ccnt_ff;
   logic [15:0] next_id_ff;
   logic [RW-1:0] free_head_ff, cpu_slot_ff, r_ff, init_ff;
   logic [CW-1:0] live_ff;
   logic cpu_occ_ff;
   logic [1:0] kind_ff, cls_ff;
   logic [31:0] mem_in_ff, len_in_ff, tag_in_ff;
   logic wr_in_ff, moved_ff;
   logic [2:0] status_ff;
   logic [QW-1:0] slot_ff;

   // Read ports.
   logic [RW-1:0] rd_addr;
   logic [15:0] rd_id_ff;
   logic [31:0] rd_mem_ff, rd_len_ff, rd_tag_ff;
   logic rd_wr_ff;
   logic [RW-1:0] rd_link_ff;
   // Write ports.
   logic rec_we, link_we;
   logic [RW-1:0] rec_wa, link_wa, link_wd;
   logic [15:0] w_id;
   logic [31:0] w_mem, w_len, w_tag;
   logic w_wr;

   always_ff @(posedge clock) begin
      if (rec_we) begin
         mem_id[rec_wa]  <= w_id;
         mem_mem[rec_wa] <= w_mem;
         mem_len[rec_wa] <= w_len;
         mem_wr[rec_wa]  <= w_wr;
         mem_tag[rec_wa] <= w_tag;
      end
      if (link_we) begin
         mem_link[link_wa] <= link_wd;
      end
      rd_id_ff   <= mem_id[rd_addr];
      rd_mem_ff  <= mem_mem[rd_addr];
      rd_len_ff  <= mem_len[rd_addr];
      rd_wr_ff   <= mem_wr[rd_addr];
      rd_tag_ff  <= mem_tag[rd_addr];
      rd_link_ff <= mem_link[rd_addr];
   end

   // Slot resolution, done when the word is captured.
   logic [2:0] res_st;
   logic [6:0] base, slot_full;
   logic [5:0] cnt;
   always_comb begin
      base = '0;
      cnt = '0;
      res_st = ST_DONE;
      unique case (req_device_class)
         CLASS_PRINTER: begin base = '0; cnt = {1'b0, pcnt_ff}; end
         CLASS_DISK:    begin base = 7'(pcnt_ff); cnt = {1'b0, dcnt_ff}; end
         CLASS_CDRW:    begin base = 7'(pcnt_ff) + 7'(dcnt_ff); cnt = {1'b0, ccnt_ff}; end
         default:       res_st = ST_NO_DEV;
      endcase
      slot_full = base + 7'(req_device_number) - 7'd1;
      if (res_st == ST_DONE) begin
         if (cnt == '0) res_st = ST_NO_DEV;
         else if (req_device_number == '0 || 6'(req_device_number) > cnt) res_st = ST_BAD_NUM;
         else if (32'(slot_full) >= 32'(MAX_DEVICES)) res_st = ST_BAD_NUM;
      end
   end

   logic [RW-1:0] head_s, tail_s;
   assign head_s = qhead_ff[slot_ff];
   assign tail_s = qtail_ff[slot_ff];

   // Memory access control per state.
   always_comb begin
      rd_addr = r_ff;
      rec_we = 1'b0; link_we = 1'b0;
      rec_wa = r_ff; link_wa = r_ff; link_wd = r_ff;
      w_id = rd_id_ff; w_mem = rd_mem_ff; w_len = rd_len_ff; w_wr = rd_wr_ff;
      w_tag = rd_tag_ff;
      unique case (state_ff)
         S_INIT: begin
            link_we = 1'b1; link_wa = init_ff; link_wd = init_ff + RW'(1);
         end
         S_RD: rd_addr = r_ff;
         S_EXEC: begin
            rd_addr = r_ff;
            if (status_ff == ST_DONE) begin
               case (kind_ff)
                  KIND_CREATE: begin
                     rec_we = 1'b1; w_id = next_id_ff; w_mem = '1; w_len = '1;
                     w_wr = 1'b1; w_tag = '0;
                  end
                  KIND_SEND: begin
                     rec_we = 1'b1; w_mem = mem_in_ff; w_tag = tag_in_ff;
                     if (cls_ff == CLASS_PRINTER) w_len = len_in_ff;
                     else begin
                        w_wr = wr_in_ff;
                        if (wr_in_ff) w_len = len_in_ff;
                     end
                  end
                  KIND_TERMINATE: begin
                     link_we = 1'b1; link_wd = free_head_ff;
                  end
                  default: ;
               endcase
            end
         end
         S_MOVE: begin
            rd_addr = r_ff;
            if (moved_ff && kind_ff != KIND_TERMINATE
                && qne_ff[(kind_ff == KIND_SEND) ? slot_ff : READY_Q]) begin
               link_we = 1'b1;
               link_wa = (kind_ff == KIND_SEND) ? tail_s : qtail_ff[READY_Q];
               link_wd = r_ff;
            end
         end
         // Read the record that sits in the CPU once the refill is done.
         S_FILL: rd_addr = (!cpu_occ_ff && qne_ff[READY_Q]) ? qhead_ff[READY_Q] : cpu_slot_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         pcnt_ff <= '0; dcnt_ff <= '0; ccnt_ff <= '0;
         next_id_ff <= '0;
         free_head_ff <= '0;
         live_ff <= '0;
         qne_ff <= '0;
         cpu_occ_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_DONE);
         if (csr_we) begin
            case (csr_index)
               CSR_PRINTER: pcnt_ff <= csr_data;
               CSR_DISK:    dcnt_ff <= csr_data;
               CSR_CDRW:    ccnt_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + RW'(1);
               if (32'(init_ff) == MAX_PROCESSES - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_kind; cls_ff <= req_device_class;
                  mem_in_ff <= req_memory_location; len_in_ff <= req_file_length;
                  wr_in_ff <= req_write_flag; tag_in_ff <= req_file_tag;
                  slot_ff <= QW'(slot_full);
                  moved_ff <= 1'b0;
                  case (req_kind)
                     KIND_CREATE: begin
                        status_ff <= (32'(live_ff) >= MAX_PROCESSES) ? ST_POOL_FULL : ST_DONE;
                        r_ff <= free_head_ff;
                     end
                     KIND_SEND: begin
                        status_ff <= (res_st != ST_DONE) ? res_st :
                                     (!cpu_occ_ff ? ST_CPU_EMPTY : ST_DONE);
                        r_ff <= cpu_slot_ff;
                     end
                     KIND_COMPLETE: begin
                        status_ff <= (res_st != ST_DONE) ? res_st :
                                     (!qne_ff[QW'(slot_full)] ? ST_Q_EMPTY : ST_DONE);
                        r_ff <= qhead_ff[QW'(slot_full)];
                     end
                     default: begin
                        status_ff <= !cpu_occ_ff ? ST_CPU_EMPTY : ST_DONE;
                        r_ff <= cpu_slot_ff;
                     end
                  endcase
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_EXEC;
            S_EXEC: begin
               // Link and record of r are valid now.
               if (status_ff == ST_DONE) begin
                  moved_ff <= 1'b1;
                  case (kind_ff)
                     KIND_CREATE: begin
                        free_head_ff <= rd_link_ff;
                        live_ff <= live_ff + CW'(1);
                        next_id_ff <= next_id_ff + 16'd1;
                     end
                     KIND_SEND: cpu_occ_ff <= 1'b0;
                     KIND_COMPLETE: begin
                        if (head_s == tail_s) qne_ff[slot_ff] <= 1'b0;
                        else qhead_ff[slot_ff] <= rd_link_ff;
                     end
                     default: begin
                        cpu_occ_ff <= 1'b0;
                        free_head_ff <= r_ff;
                        if (live_ff != '0) live_ff <= live_ff - CW'(1);
                     end
                  endcase
               end
               state_ff <= S_MOVE;
            end
            S_MOVE: begin
               // Push onto the target queue; the record is re-read after its write.
               if (moved_ff && kind_ff != KIND_TERMINATE) begin
                  if (kind_ff == KIND_SEND) begin
                     if (!qne_ff[slot_ff]) qhead_ff[slot_ff] <= r_ff;
                     qtail_ff[slot_ff] <= r_ff;
                     qne_ff[slot_ff] <= 1'b1;
                  end else begin
                     if (!qne_ff[READY_Q]) qhead_ff[READY_Q] <= r_ff;
                     qtail_ff[READY_Q] <= r_ff;
                     qne_ff[READY_Q] <= 1'b1;
                  end
               end
               state_ff <= S_FILL;
            end
            S_FILL: begin
               // The moved record as it stands after the write is on the read port now.
               if (moved_ff) begin
                  rsp_moved_pid <= rd_id_ff; rsp_moved_memory <= rd_mem_ff;
                  rsp_moved_length <= rd_len_ff; rsp_moved_write <= rd_wr_ff;
                  rsp_moved_tag <= rd_tag_ff;
               end else begin
                  rsp_moved_pid <= '0; rsp_moved_memory <= '0;
                  rsp_moved_length <= '0; rsp_moved_write <= 1'b0;
                  rsp_moved_tag <= '0;
               end
               if (!cpu_occ_ff && qne_ff[READY_Q]) begin
                  cpu_slot_ff <= qhead_ff[READY_Q];
                  cpu_occ_ff <= 1'b1;
                  if (qhead_ff[READY_Q] == qtail_ff[READY_Q]) qne_ff[READY_Q] <= 1'b0;
                  r_ff <= qhead_ff[READY_Q];
               end else begin
                  r_ff <= cpu_slot_ff;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // Head record and link are read; finish the pop and report.
               if (cpu_occ_ff && r_ff == cpu_slot_ff && qhead_ff[READY_Q] == r_ff
                   && qne_ff[READY_Q])
                  qhead_ff[READY_Q] <= rd_link_ff;
               rsp_status <= status_ff;
               rsp_cpu_busy <= cpu_occ_ff;
               rsp_cpu_pid <= cpu_occ_ff ? rd_id_ff : 16'd0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);

   `PQM_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `PQM_ASSERT_IMP(a_live_range, clock, reset, 1'b1, 32'(live_ff) <= MAX_PROCESSES)
   `PQM_ASSERT_IMP(a_idle_pid, clock, reset, rsp_valid && !rsp_cpu_busy, rsp_cpu_pid == 16'd0)
endmodule

/* tb/tb_process_queue_manager.sv */
// Self-checking testbench for the process queue manager: random events checked against a predictor.
`timescale 1ns / 1ps
module tb_process_queue_manager;
   import pqm_pkg::*;

   localparam int POOL_SIZE = 64;
   localparam int DEV_SLOTS = 16;
   localparam int READY_FIFO = DEV_SLOTS;
   localparam int STALL_LIMIT = 600;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  cls;
      logic [4:0]  num;
      logic [31:0] mem;
      logic [31:0] len;
      logic        wr;
      logic [31:0] tag;
      bit          hold;
   } event_type;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] pid;
      logic [31:0] mem;
      logic [31:0] len;
      logic        wr;
      logic [31:0] tag;
      logic        cpu_busy;
      logic [15:0] cpu_pid;
   } outcome_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_kind = '0;
   logic [1:0]  req_device_class = '0;
   logic [4:0]  req_device_number = '0;
   logic signed [31:0] req_memory_location = '0;
   logic signed [31:0] req_file_length = '0;
   logic        req_write_flag = 0;
   logic [31:0] req_file_tag = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_moved_pid;
   logic signed [31:0] rsp_moved_memory;
   logic signed [31:0] rsp_moved_length;
   logic        rsp_moved_write;
   logic [31:0] rsp_moved_tag;
   logic        rsp_cpu_busy;
   logic [15:0] rsp_cpu_pid;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_data = '0;

   process_queue_manager i_dut (.*);

   always #5 clock = ~clock;

   // Shadow state of the block.
   int unsigned n_printer, n_disk, n_cdrw;
   logic [15:0] next_pid;
   logic [15:0] rec_pid [POOL_SIZE];
   logic [31:0] rec_mem [POOL_SIZE];
   logic [31:0] rec_len [POOL_SIZE];
   logic        rec_wr [POOL_SIZE];
   logic [31:0] rec_tag [POOL_SIZE];
   int          rec_link [POOL_SIZE];
   int          free_ptr, live_recs, cpu_rec;
   bit          cpu_full;
   int          fifo_head [DEV_SLOTS + 1];
   int          fifo_tail [DEV_SLOTS + 1];
   bit          fifo_full [DEV_SLOTS + 1];

   event_type   pending_events[$];
   outcome_type awaited_outcomes[$];
   event_type   cur_event;
   int       gap_left = 0;
   bit       no_idle = 0;
   int       fails = 0;
   int       quiet_cycles = 0;

   function automatic void fifo_push(int q, int r);
      if (fifo_full[q]) begin
         rec_link[fifo_tail[q]] = r;
         fifo_tail[q] = r;
      end else begin
         fifo_head[q] = r;
         fifo_tail[q] = r;
         fifo_full[q] = 1;
      end
   endfunction

   function automatic int fifo_pop(int q);
      int r;
      r = fifo_head[q];
      if (r == fifo_tail[q]) fifo_full[q] = 0;
      else fifo_head[q] = rec_link[r];
      return r;
   endfunction

   function automatic logic [2:0] locate_device(logic [1:0] cls, int unsigned num,
                                                output int slot);
      int unsigned base, cnt;
      slot = 0;
      case (cls)
         CLASS_PRINTER: begin base = 0; cnt = n_printer; end
         CLASS_DISK: begin base = n_printer; cnt = n_disk; end
         CLASS_CDRW: begin base = n_printer + n_disk; cnt = n_cdrw; end
         default: return ST_NO_DEV;
      endcase
      if (cnt == 0) return ST_NO_DEV;
      if (num == 0 || num > cnt) return ST_BAD_NUM;
      if (base + num - 1 >= DEV_SLOTS) return ST_BAD_NUM;
      slot = base + num - 1;
      return ST_DONE;
   endfunction

   function automatic outcome_type apply_event(event_type e);
      outcome_type o;
      int slot, r;
      bit moved;
      o = '{default: '0};
      o.status = ST_DONE;
      r = 0;
      moved = 0;
      case (e.kind)
         KIND_CREATE: begin
            if (live_recs >= POOL_SIZE) o.status = ST_POOL_FULL;
            else begin
               r = free_ptr;
               free_ptr = rec_link[r];
               live_recs++;
               rec_pid[r] = next_pid;
               next_pid++;
               rec_mem[r] = '1;
               rec_len[r] = '1;
               rec_wr[r] = 1;
               rec_tag[r] = '0;
               fifo_push(READY_FIFO, r);
               moved = 1;
            end
         end
         KIND_SEND: begin
            o.status = locate_device(e.cls, e.num, slot);
            if (o.status == ST_DONE && !cpu_full) o.status = ST_CPU_EMPTY;
            if (o.status == ST_DONE) begin
               r = cpu_rec;
               cpu_full = 0;
               rec_mem[r] = e.mem;
               rec_tag[r] = e.tag;
               if (e.cls == CLASS_PRINTER) rec_len[r] = e.len;
               else begin
                  rec_wr[r] = e.wr;
                  if (e.wr) rec_len[r] = e.len;
               end
               fifo_push(slot, r);
               moved = 1;
            end
         end
         KIND_COMPLETE: begin
            o.status = locate_device(e.cls, e.num, slot);
            if (o.status == ST_DONE && !fifo_full[slot]) o.status = ST_Q_EMPTY;
            if (o.status == ST_DONE) begin
               r = fifo_pop(slot);
               fifo_push(READY_FIFO, r);
               moved = 1;
            end
         end
         default: begin
            if (!cpu_full) o.status = ST_CPU_EMPTY;
            else begin
               r = cpu_rec;
               cpu_full = 0;
               rec_link[r] = free_ptr;
               free_ptr = r;
               if (live_recs > 0) live_recs--;
               moved = 1;
            end
         end
      endcase
      if (moved) begin
         o.pid = rec_pid[r];
         o.mem = rec_mem[r];
         o.len = rec_len[r];
         o.wr = rec_wr[r];
         o.tag = rec_tag[r];
      end
      // An empty CPU picks up the head of the ready FIFO after every event.
      if (!cpu_full && fifo_full[READY_FIFO]) begin
         cpu_rec = fifo_pop(READY_FIFO);
         cpu_full = 1;
      end
      o.cpu_busy = cpu_full;
      o.cpu_pid = cpu_full ? rec_pid[cpu_rec] : 16'd0;
      return o;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic event_type make_event(logic [1:0] kind, logic [1:0] cls, int num);
      event_type e;
      e.kind = kind;
      e.cls = cls;
      e.num = 5'(num);
      e.mem = pick_word();
      e.len = pick_word();
      e.wr = 1'($urandom_range(0, 1));
      e.tag = pick_word();
      e.hold = 0;
      return e;
   endfunction

   function automatic event_type random_event();
      int unsigned w, cnt;
      logic [1:0] kind, cls;
      int num;
      w = $urandom_range(0, 99);
      kind = w < 30 ? KIND_CREATE : w < 62 ? KIND_SEND : w < 90 ? KIND_COMPLETE
                                                       : KIND_TERMINATE;
      cls = $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      cnt = cls == CLASS_PRINTER ? n_printer : cls == CLASS_DISK ? n_disk : n_cdrw;
      if (cnt > 0 && $urandom_range(0, 9) != 0) num = $urandom_range(1, cnt);
      else num = $urandom_range(0, 31);
      random_event = make_event(kind, cls, num);
      random_event.hold = $urandom_range(0, 39) == 0;
   endfunction

   function automatic void add_event(event_type e);
      pending_events.insert(pending_events.size(), e);
   endfunction

   // Driver: the next word goes out once the previous one is taken, after any random gap or hold.
   always @(posedge clock) begin
      bit fire, drive;
      fire = start && !busy;
      drive = 0;
      if (fire) awaited_outcomes.insert(awaited_outcomes.size(), apply_event(cur_event));
      if (!reset && (!start || fire)) begin
         if (gap_left > 0) gap_left--;
         else if (pending_events.size() > 0 &&
                  !(pending_events[0].hold && (fire || awaited_outcomes.size() > 0))) begin
            cur_event = pending_events[0];
            pending_events.delete(0);
            req_kind <= cur_event.kind;
            req_device_class <= cur_event.cls;
            req_device_number <= cur_event.num;
            req_memory_location <= cur_event.mem;
            req_file_length <= cur_event.len;
            req_write_flag <= cur_event.wr;
            req_file_tag <= cur_event.tag;
            drive = 1;
            if (!no_idle && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
         end
         start <= drive;
      end
   end

   // Monitor: every strobed word is checked against the oldest prediction.
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            $error("unexpected result word, status %0d", rsp_status);
            fails++;
         end else begin
            exp_o = awaited_outcomes[0];
            awaited_outcomes.delete(0);
            if (rsp_status !== exp_o.status) begin
               $error("status: expected %0d, got %0d", exp_o.status, rsp_status);
               fails++;
            end
            if (rsp_moved_pid !== exp_o.pid) begin
               $error("moved_pid: expected %0d, got %0d", exp_o.pid, rsp_moved_pid);
               fails++;
            end
            if (rsp_moved_memory !== exp_o.mem) begin
               $error("moved_memory: expected %h, got %h", exp_o.mem, rsp_moved_memory);
               fails++;
            end
            if (rsp_moved_length !== exp_o.len) begin
               $error("moved_length: expected %h, got %h", exp_o.len, rsp_moved_length);
               fails++;
            end
            if (rsp_moved_write !== exp_o.wr) begin
               $error("moved_write: expected %0d, got %0d", exp_o.wr, rsp_moved_write);
               fails++;
            end
            if (rsp_moved_tag !== exp_o.tag) begin
               $error("moved_tag: expected %h, got %h", exp_o.tag, rsp_moved_tag);
               fails++;
            end
            if (rsp_cpu_busy !== exp_o.cpu_busy) begin
               $error("cpu_busy: expected %0d, got %0d", exp_o.cpu_busy, rsp_cpu_busy);
               fails++;
            end
            if (rsp_cpu_pid !== exp_o.cpu_pid) begin
               $error("cpu_pid: expected %0d, got %0d", exp_o.cpu_pid, rsp_cpu_pid);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_process_queue_manager: FAIL");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_events.size() > 0 || start || awaited_outcomes.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_counts(int unsigned p, int unsigned d, int unsigned c);
      @(posedge clock);
      csr_we <= 1; csr_index <= CSR_PRINTER; csr_data <= 5'(p);
      @(posedge clock);
      csr_index <= CSR_DISK; csr_data <= 5'(d);
      @(posedge clock);
      csr_index <= CSR_CDRW; csr_data <= 5'(c);
      @(posedge clock);
      csr_we <= 0;
      n_printer = p;
      n_disk = d;
      n_cdrw = c;
   endtask

   initial begin
      int unsigned cfg [8][3];
      cfg = '{'{0, 0, 0}, '{2, 3, 1}, '{16, 16, 16}, '{1, 1, 1},
              '{7, 9, 16}, '{2, 0, 5}, '{0, 16, 0}, '{5, 6, 5}};
      n_printer = 0; n_disk = 0; n_cdrw = 0;
      next_pid = 0;
      for (int i = 0; i < POOL_SIZE; i++) rec_link[i] = (i + 1) % POOL_SIZE;
      free_ptr = 0; live_recs = 0; cpu_rec = 0; cpu_full = 0;
      for (int q = 0; q <= DEV_SLOTS; q++) fifo_full[q] = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // With no devices every request but the create fails; the CPU starts empty.
      add_event(make_event(KIND_TERMINATE, CLASS_PRINTER, 1));
      add_event(make_event(KIND_SEND, CLASS_DISK, 1));
      add_event(make_event(KIND_COMPLETE, CLASS_CDRW, 1));
      add_event(make_event(KIND_SEND, 2'd3, 31));
      add_event(make_event(KIND_CREATE, CLASS_PRINTER, 0));
      add_event(make_event(KIND_SEND, CLASS_PRINTER, 1));
      wait_idle();
      set_counts(2, 3, 1);
      add_event(make_event(KIND_CREATE, CLASS_PRINTER, 0));
      add_event(make_event(KIND_CREATE, CLASS_PRINTER, 0));
      add_event(make_event(KIND_SEND, CLASS_PRINTER, 2));
      add_event(make_event(KIND_SEND, CLASS_DISK, 3));
      pending_events[$].wr = 1;
      add_event(make_event(KIND_SEND, CLASS_CDRW, 1));
      pending_events[$].wr = 0;
      add_event(make_event(KIND_SEND, CLASS_DISK, 0));
      add_event(make_event(KIND_SEND, CLASS_DISK, 4));
      add_event(make_event(KIND_COMPLETE, CLASS_DISK, 1));
      add_event(make_event(KIND_COMPLETE, CLASS_PRINTER, 2));
      add_event(make_event(KIND_COMPLETE, CLASS_DISK, 3));
      add_event(make_event(KIND_COMPLETE, CLASS_CDRW, 1));
      add_event(make_event(KIND_TERMINATE, CLASS_PRINTER, 0));
      pending_events[$].hold = 1;
      add_event(make_event(KIND_TERMINATE, CLASS_PRINTER, 0));

      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         set_counts(cfg[ph][0], cfg[ph][1], cfg[ph][2]);
         if (ph == 7) no_idle = 1;
         // One phase fills the pool past its limit.
         if (ph == 3)
            for (int i = 0; i < 66; i++)
               add_event(make_event(KIND_CREATE, CLASS_PRINTER, 0));
         for (int i = 0; i < 58; i++) add_event(random_event());
      end

      wait_idle();
      if (fails == 0) $display("tb_process_queue_manager: PASS");
      else $display("tb_process_queue_manager: FAIL");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pqm_pkg.sv
rtl/core/process_queue_manager.sv
tb/tb_process_queue_manager.sv
